// ----- src/dbs_pkg.sv -----
// Shared types and constants for the bucket store.
package dbs_pkg;

    localparam int BUCKETS          = 64;
    localparam int SLOTS_PER_BUCKET = 16;

    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int SLOT_W  = $clog2(SLOTS_PER_BUCKET);
    localparam int FILL_W  = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int ENT_AW  = BKT_W + SLOT_W;
    localparam int ENTRIES = BUCKETS * SLOTS_PER_BUCKET;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_CAPTURE = 2'd1,
        CMD_LOOKUP  = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_BAD_BKT = 3'd3,
        ST_BAD_IDX = 3'd4
    } t_status;

    // Source of the reported count.
    typedef enum logic [1:0] {
        CNT_ZERO = 2'd0,
        CNT_FILL = 2'd1,
        CNT_INC  = 2'd2,
        CNT_CAP  = 2'd3
    } t_cnt_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DUP,
        S_WRITE,
        S_LOOK
    } t_state;

    typedef struct packed {
        t_cmd        command;
        logic [7:0]  bucket_num;
        logic [31:0] buffer_id;
        logic [15:0] binding_slot;
        logic [15:0] heap_slot;
        logic [7:0]  entry_index;
        logic        capture_on;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [4:0]  entry_count;
        logic [31:0] found_buffer_id;
        logic [15:0] found_binding_slot;
        logic [15:0] found_heap_slot;
        logic        capture_active;
        logic        full_warned;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic     load_item;
        logic     scan_init;
        logic     scan_step;
        logic     look_rd;
        logic     wr_entry;
        logic     set_warn;
        logic     cap_write;
        logic     load_out;
        logic     use_data;
        t_status  status;
        t_cnt_sel cnt_sel;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_cmd command;
        logic bkt_ok;
        logic full;
        logic fill_zero;
        logic idx_bad;
        logic hit;
        logic scan_end;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- src/dedup_bucket_store_core.sv -----
// Top level of the deduplicating bucket store.
//
// Channel    | Dir | Accept when                      | Payload
// -----------+-----+----------------------------------+-----------------------------------
// s_axis     | in  | i_s_axis_tvalid & o_s_axis_tready| tuser=command, tdata=item fields
// m_axis     | out | o_m_axis_tvalid & i_m_axis_tready| tuser=status,  tdata=result fields
//
// One item at a time. Capture, bad bucket, full bucket, bad index and count queries give their result
// straight from S_CHECK; any other lookup reads the entry first. Insert into an empty bucket goes
// straight to the write; otherwise it first runs the duplicate scan, which reads one stored entry per
// cycle from the single-port store; a duplicate ends the scan early.
// Reset (sync, active low) empties every bucket through per-bucket valid bits;
// the entry store itself is not cleared. The next item is taken while a
// result still waits in the output register; the block stalls only when a new
// result is ready and the old one has not been taken.
module dedup_bucket_store_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] bucket_num, [39:8] buffer_id, [55:40] binding_slot,
    // [71:56] heap_slot, [79:72] entry_index, [80] capture_on, [87:81] zero
    input  logic [87:0] i_s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [4:0] entry_count, [36:5] found_buffer_id, [52:37] found_binding_slot,
    // [68:53] found_heap_slot, [69] capture_active, [70] full_warned, [71] zero
    output logic [71:0] o_m_axis_tdata,
    // [2:0] status
    output logic [2:0]  o_m_axis_tuser
);
    import dbs_pkg::*;

    t_item   item;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_result res;

    // unpack the input item
    assign item.command      = t_cmd'(i_s_axis_tuser);
    assign item.bucket_num   = i_s_axis_tdata[7:0];
    assign item.buffer_id    = i_s_axis_tdata[39:8];
    assign item.binding_slot = i_s_axis_tdata[55:40];
    assign item.heap_slot    = i_s_axis_tdata[71:56];
    assign item.entry_index  = i_s_axis_tdata[79:72];
    assign item.capture_on   = i_s_axis_tdata[80];

    dbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    dbs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_result    (res)
    );

    // pack the result item
    assign o_m_axis_tuser = res.status;
    assign o_m_axis_tdata = {1'b0, res.full_warned, res.capture_active,
                             res.found_heap_slot, res.found_binding_slot,
                             res.found_buffer_id, res.entry_count};

endmodule

// ----- src/dbs_ctrl.sv -----
// Sequencing state machine for the bucket store.
module dbs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dbs_pkg::t_dp_sts i_sts,
    output dbs_pkg::t_dp_cmd o_cmd
);
    import dbs_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        c         = '0;
        c.status  = ST_OK;
        c.cnt_sel = CNT_FILL;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    c.load_item = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.bkt_ok && i_sts.command != CMD_CAPTURE) begin
                    if (i_sts.out_free) begin
                        c.load_out = 1'b1;
                        c.status   = ST_BAD_BKT;
                        c.cnt_sel  = CNT_ZERO;
                        n_state    = S_IDLE;
                    end
                end else begin
                    case (i_sts.command)
                        CMD_CAPTURE: begin
                            if (i_sts.out_free) begin
                                c.load_out  = 1'b1;
                                c.cap_write = 1'b1;
                                c.cnt_sel   = CNT_CAP;
                                n_state     = S_IDLE;
                            end
                        end
                        CMD_INSERT: begin
                            if (i_sts.full) begin
                                if (i_sts.out_free) begin
                                    c.load_out = 1'b1;
                                    c.set_warn = 1'b1;
                                    c.status   = ST_FULL;
                                    n_state    = S_IDLE;
                                end
                            end else if (i_sts.fill_zero) begin
                                n_state = S_WRITE;
                            end else begin
                                c.scan_init = 1'b1;
                                n_state     = S_SCAN;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (i_sts.idx_bad) begin
                                if (i_sts.out_free) begin
                                    c.load_out = 1'b1;
                                    c.status   = ST_BAD_IDX;
                                    n_state    = S_IDLE;
                                end
                            end else begin
                                c.look_rd = 1'b1;
                                n_state   = S_LOOK;
                            end
                        end
                        default: begin
                            if (i_sts.out_free) begin
                                c.load_out = 1'b1;
                                n_state    = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                c.scan_step = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_DUP;
                end else if (i_sts.scan_end) begin
                    n_state = S_WRITE;
                end
            end
            S_DUP: begin
                if (i_sts.out_free) begin
                    c.load_out = 1'b1;
                    c.status   = ST_DUP;
                    n_state    = S_IDLE;
                end
            end
            S_WRITE: begin
                if (i_sts.out_free) begin
                    c.load_out = 1'b1;
                    c.wr_entry = 1'b1;
                    c.cnt_sel  = CNT_INC;
                    n_state    = S_IDLE;
                end
            end
            S_LOOK: begin
                if (i_sts.out_free) begin
                    c.load_out = 1'b1;
                    c.use_data = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = c;
    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- src/dbs_dpath.sv -----
// Datapath: item registers, fill and entry memories, scan compare, result register.
module dbs_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dbs_pkg::t_item   i_item,
    input  dbs_pkg::t_dp_cmd i_cmd,
    output dbs_pkg::t_dp_sts o_sts,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output dbs_pkg::t_result o_result
);
    import dbs_pkg::*;

    // item registers
    t_cmd        r_cmd;
    logic        r_bkt_ok;
    logic [BKT_W-1:0] r_bkt;
    logic [31:0] r_buf;
    logic [15:0] r_bind;
    logic [15:0] r_heap;
    logic [7:0]  r_eidx;
    logic        r_on;

    // global flags
    logic        r_cap;
    logic        r_warn;
    logic        n_cap;
    logic        n_warn;
    logic        clear;

    // per-bucket fill: memory plus one valid bit per bucket
    logic [FILL_W-1:0] r_fmem [BUCKETS];
    logic [BUCKETS-1:0] r_fill_vld;
    logic [FILL_W-1:0] r_fill_q;
    logic        r_fvld_q;
    logic [FILL_W-1:0] fill;
    logic [FILL_W-1:0] fill_inc;
    logic [BKT_W-1:0] in_bkt;

    // entry store
    logic [63:0] r_emem [ENTRIES];
    logic [63:0] r_rd_data;
    logic        rd_en;
    logic [ENT_AW-1:0] rd_addr;
    logic [ENT_AW-1:0] wr_addr;

    // scan
    logic [FILL_W-1:0] r_idx;
    logic        r_pend;
    logic        issue;
    logic        match;

    // result
    logic        r_out_vld;
    t_result     r_res;
    logic [FILL_W-1:0] cnt;

    assign in_bkt   = i_item.bucket_num[BKT_W-1:0];
    assign fill     = r_fvld_q ? r_fill_q : '0;
    assign fill_inc = fill + FILL_W'(1);
    assign clear    = i_cmd.cap_write && r_on && !r_cap;
    assign n_cap    = i_cmd.cap_write ? r_on : r_cap;
    assign n_warn   = clear ? 1'b0 : (i_cmd.set_warn ? 1'b1 : r_warn);

    assign issue   = i_cmd.scan_step && (r_idx < fill);
    assign match   = (r_rd_data[63:32] == r_buf) && (r_rd_data[31:16] == r_bind);
    assign rd_en   = issue || i_cmd.look_rd;
    assign rd_addr = i_cmd.look_rd ? {r_bkt, r_eidx[SLOT_W-1:0]}
                                   : {r_bkt, r_idx[SLOT_W-1:0]};
    assign wr_addr = {r_bkt, fill[SLOT_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd    <= i_item.command;
            r_bkt_ok <= (32'(i_item.bucket_num) < BUCKETS);
            r_bkt    <= in_bkt;
            r_buf    <= i_item.buffer_id;
            r_bind   <= i_item.binding_slot;
            r_heap   <= i_item.heap_slot;
            r_eidx   <= i_item.entry_index;
            r_on     <= i_item.capture_on;
            r_fill_q <= r_fmem[in_bkt];
            r_fvld_q <= r_fill_vld[in_bkt];
        end
        if (i_cmd.wr_entry) begin
            r_fmem[r_bkt] <= fill_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry) begin
            r_emem[wr_addr] <= {r_buf, r_bind, r_heap};
        end
        if (rd_en) begin
            r_rd_data <= r_emem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= 1'b0;
            r_warn     <= 1'b0;
            r_fill_vld <= '0;
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_cap  <= n_cap;
            r_warn <= n_warn;
            if (clear) begin
                r_fill_vld <= '0;
            end else if (i_cmd.wr_entry) begin
                r_fill_vld[r_bkt] <= 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (issue) begin
                    r_idx <= r_idx + FILL_W'(1);
                end
                r_pend <= issue;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        case (i_cmd.cnt_sel)
            CNT_ZERO: cnt = '0;
            CNT_FILL: cnt = fill;
            CNT_INC:  cnt = fill_inc;
            CNT_CAP:  cnt = (r_bkt_ok && !clear) ? fill : '0;
            default:  cnt = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_res.status             <= i_cmd.status;
            r_res.entry_count        <= 5'(cnt);
            r_res.found_buffer_id    <= i_cmd.use_data ? r_rd_data[63:32] : '0;
            r_res.found_binding_slot <= i_cmd.use_data ? r_rd_data[31:16] : '0;
            r_res.found_heap_slot    <= i_cmd.use_data ? r_rd_data[15:0]  : '0;
            r_res.capture_active     <= n_cap;
            r_res.full_warned        <= n_warn;
        end
    end

    assign o_sts.command   = r_cmd;
    assign o_sts.bkt_ok    = r_bkt_ok;
    assign o_sts.full      = (fill >= FILL_W'(SLOTS_PER_BUCKET));
    assign o_sts.fill_zero = (fill == '0);
    assign o_sts.idx_bad   = (32'(r_eidx) >= 32'(fill));
    assign o_sts.hit       = r_pend && match;
    assign o_sts.scan_end  = !issue && !r_pend;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_result    = r_res;

    a_wr_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_entry |-> (r_bkt_ok && fill < FILL_W'(SLOTS_PER_BUCKET)))
        else $error("entry write into a full or bad bucket");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_vld || i_out_ready))
        else $error("result loaded over an untaken result");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear |=> (r_fill_vld == '0) && !r_warn && r_cap)
        else $error("capture start did not empty the buckets");

    a_scan_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_entry || i_cmd.look_rd) |-> !issue)
        else $error("scan read collides with write or lookup");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the deduplicating bucket store: directed table, then random.
module testbench;
    import dbs_pkg::*;

    localparam int LIMIT_CYCLES    = 400_000;
    localparam int ITEMS_PER_PHASE = 643;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct packed {
        logic [31:0] buffer_id;
        logic [15:0] binding_slot;
        logic [15:0] heap_slot;
    } t_held_entry;

    // One directed item; want is used only when typed is set.
    typedef struct {
        t_item   item;
        bit      typed;
        t_result want;
    } t_directed_row;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [87:0] s_data  = '0;
    logic [1:0]  s_user  = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [71:0] m_data;
    logic [2:0]  m_user;

    // Shadow copy of the store contents.
    t_held_entry held_entries [BUCKETS][SLOTS_PER_BUCKET];
    int unsigned held_fill [BUCKETS];
    bit          held_warned;
    bit          held_capture;

    t_result expected_results [$];
    int      send_gap_pct;
    int      recv_stall_pct;
    int      mismatch_count;
    int      result_count;
    int      cycle_count;
    int      hot_bkt [2];

    dedup_bucket_store_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("FAIL");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("mismatch at result %0d: %s", result_count, msg);
        mismatch_count++;
    endtask

    // Expected result of one item; updates the shadow state.
    function automatic t_result predict_store(input t_item it);
        t_result r;
        int      bkt;
        int      fill;
        bit      in_range;
        r        = '0;
        bkt      = int'(it.bucket_num);
        in_range = bkt < BUCKETS;
        if (it.command == CMD_CAPTURE) begin
            // off to on empties every bucket and clears the warning
            if (it.capture_on && !held_capture) begin
                foreach (held_fill[b]) held_fill[b] = 0;
                held_warned = 1'b0;
            end
            held_capture = it.capture_on;
            r.status     = ST_OK;
            if (in_range) r.entry_count = 5'(held_fill[bkt]);
        end else if (!in_range) begin
            r.status = ST_BAD_BKT;
        end else begin
            fill          = held_fill[bkt];
            r.status      = ST_OK;
            r.entry_count = 5'(fill);
            case (it.command)
                CMD_INSERT: begin
                    if (fill >= SLOTS_PER_BUCKET) begin
                        held_warned = 1'b1;
                        r.status    = ST_FULL;
                    end else begin
                        for (int k = 0; k < fill; k++) begin
                            if (held_entries[bkt][k].buffer_id == it.buffer_id &&
                                held_entries[bkt][k].binding_slot == it.binding_slot)
                                r.status = ST_DUP;
                        end
                        if (r.status == ST_OK) begin
                            held_entries[bkt][fill] =
                                '{it.buffer_id, it.binding_slot, it.heap_slot};
                            held_fill[bkt] = fill + 1;
                            r.entry_count  = 5'(fill + 1);
                        end
                    end
                end
                CMD_LOOKUP: begin
                    if (int'(it.entry_index) >= fill) begin
                        r.status = ST_BAD_IDX;
                    end else begin
                        r.found_buffer_id    = held_entries[bkt][it.entry_index].buffer_id;
                        r.found_binding_slot = held_entries[bkt][it.entry_index].binding_slot;
                        r.found_heap_slot    = held_entries[bkt][it.entry_index].heap_slot;
                    end
                end
                default: ;  // count query
            endcase
        end
        r.capture_active = held_capture;
        r.full_warned    = held_warned;
        return r;
    endfunction

    function automatic t_item mk_item(input t_cmd cmd, input int ev, input logic [31:0] bid,
                                      input logic [15:0] bslot, input logic [15:0] hslot,
                                      input int idx, input bit on);
        t_item it;
        it.command      = cmd;
        it.bucket_num   = 8'(ev);
        it.buffer_id    = bid;
        it.binding_slot = bslot;
        it.heap_slot    = hslot;
        it.entry_index  = 8'(idx);
        it.capture_on   = on;
        return it;
    endfunction

    function automatic t_result mk_want(input t_status st, input int cnt, input bit cap,
                                        input bit warn);
        t_result r;
        r                = '0;
        r.status         = st;
        r.entry_count    = 5'(cnt);
        r.capture_active = cap;
        r.full_warned    = warn;
        return r;
    endfunction

    // Most traffic goes to two hot buckets so they fill up, refuse inserts
    // and raise the warning; a small id pool makes duplicates common.
    function automatic t_item random_item();
        t_item it;
        int    roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)      it.command = CMD_INSERT;
        else if (roll < 88) it.command = CMD_LOOKUP;
        else if (roll < 96) it.command = CMD_NOP;
        else                it.command = CMD_CAPTURE;
        roll = $urandom_range(0, 99);
        if (roll < 60)      it.bucket_num = 8'(hot_bkt[$urandom_range(0, 1)]);
        else if (roll < 90) it.bucket_num = 8'($urandom_range(0, BUCKETS - 1));
        else                it.bucket_num = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) begin
            it.buffer_id    = $urandom_range(0, 5);
            it.binding_slot = 16'($urandom_range(0, 3));
        end else begin
            it.buffer_id    = $urandom();
            it.binding_slot = 16'($urandom());
        end
        it.heap_slot = 16'($urandom());
        if ($urandom_range(0, 3) != 0) it.entry_index = 8'($urandom_range(0, SLOTS_PER_BUCKET));
        else                           it.entry_index = 8'($urandom_range(0, 255));
        // capture mostly on, so buckets live long enough to fill
        if (it.command == CMD_CAPTURE) it.capture_on = ($urandom_range(0, 3) != 0);
        else                           it.capture_on = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Called just after a rising clock; returns once the store has accepted the item.
    task automatic send_item(input t_item it, input bit typed, input t_result want);
        t_result predicted;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= it.command;
        s_data  <= {7'd0, it.capture_on, it.entry_index, it.heap_slot, it.binding_slot,
                    it.buffer_id, it.bucket_num};
        do @(posedge clk); while (s_ready !== 1'b1);
        predicted = predict_store(it);
        expected_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge clk) begin : result_check
        t_result got;
        t_result want;
        if (rst_n && m_valid === 1'b1 && m_ready) begin
            got.status             = t_status'(m_user);
            got.entry_count        = m_data[4:0];
            got.found_buffer_id    = m_data[36:5];
            got.found_binding_slot = m_data[52:37];
            got.found_heap_slot    = m_data[68:53];
            got.capture_active     = m_data[69];
            got.full_warned        = m_data[70];
            if (expected_results.size() == 0) begin
                note_mismatch("result with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    note_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.entry_count !== want.entry_count)
                    note_mismatch($sformatf("entry_count %0d, want %0d",
                                            got.entry_count, want.entry_count));
                if (got.found_buffer_id !== want.found_buffer_id)
                    note_mismatch($sformatf("found_buffer_id %h, want %h",
                                            got.found_buffer_id, want.found_buffer_id));
                if (got.found_binding_slot !== want.found_binding_slot)
                    note_mismatch($sformatf("found_binding_slot %h, want %h",
                                            got.found_binding_slot, want.found_binding_slot));
                if (got.found_heap_slot !== want.found_heap_slot)
                    note_mismatch($sformatf("found_heap_slot %h, want %h",
                                            got.found_heap_slot, want.found_heap_slot));
                if (got.capture_active !== want.capture_active)
                    note_mismatch($sformatf("capture_active %b, want %b",
                                            got.capture_active, want.capture_active));
                if (got.full_warned !== want.full_warned)
                    note_mismatch($sformatf("full_warned %b, want %b",
                                            got.full_warned, want.full_warned));
            end
            result_count++;
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        t_directed_row directed_rows [$];
        send_gap_pct   = 30;
        recv_stall_pct = 30;

        // after reset: nothing stored, capture off
        directed_rows.push_back('{mk_item(CMD_LOOKUP, 0, 0, 0, 0, 0, 0), 1'b1,
                                  mk_want(ST_BAD_IDX, 0, 0, 0)});
        // out-of-range buckets, top value and first one past the end
        directed_rows.push_back('{mk_item(CMD_INSERT, 255, '1, '1, '1, 255, 1), 1'b1,
                                  mk_want(ST_BAD_BKT, 0, 0, 0)});
        directed_rows.push_back('{mk_item(CMD_LOOKUP, BUCKETS, 0, 0, 0, 0, 0), 1'b1,
                                  mk_want(ST_BAD_BKT, 0, 0, 0)});
        directed_rows.push_back('{mk_item(CMD_NOP, BUCKETS - 1, 0, 0, 0, 0, 0), 1'b1,
                                  mk_want(ST_OK, 0, 0, 0)});
        directed_rows.push_back('{mk_item(CMD_NOP, 128, 0, 0, 0, 0, 0), 1'b1,
                                  mk_want(ST_BAD_BKT, 0, 0, 0)});
        directed_rows.push_back('{mk_item(CMD_CAPTURE, 0, 0, 0, 0, 0, 1), 1'b1,
                                  mk_want(ST_OK, 0, 1, 0)});
        // all-ones entry in the last bucket, then its duplicate
        directed_rows.push_back('{mk_item(CMD_INSERT, BUCKETS - 1, '1, '1, '1, 255, 1), 1'b1,
                                  mk_want(ST_OK, 1, 1, 0)});
        directed_rows.push_back('{mk_item(CMD_INSERT, BUCKETS - 1, '1, '1, 0, 0, 0), 1'b1,
                                  mk_want(ST_DUP, 1, 1, 0)});
        // same buffer, other binding: a new entry
        directed_rows.push_back('{mk_item(CMD_INSERT, BUCKETS - 1, '1, 0, 16'h1234, 0, 0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_item(CMD_LOOKUP, BUCKETS - 1, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_item(CMD_LOOKUP, BUCKETS - 1, 0, 0, 0, 1, 0), 1'b0, '0});
        // index at and far beyond the fill
        directed_rows.push_back('{mk_item(CMD_LOOKUP, BUCKETS - 1, 0, 0, 0, 255, 0), 1'b1,
                                  mk_want(ST_BAD_IDX, 2, 1, 0)});
        directed_rows.push_back('{mk_item(CMD_LOOKUP, BUCKETS - 1, 0, 0, 0, 2, 0), 1'b1,
                                  mk_want(ST_BAD_IDX, 2, 1, 0)});
        // capture on while on, then off: contents kept
        directed_rows.push_back('{mk_item(CMD_CAPTURE, BUCKETS - 1, 0, 0, 0, 0, 1), 1'b1,
                                  mk_want(ST_OK, 2, 1, 0)});
        directed_rows.push_back('{mk_item(CMD_CAPTURE, BUCKETS - 1, 0, 0, 0, 0, 0), 1'b1,
                                  mk_want(ST_OK, 2, 0, 0)});
        // inserts still accepted with capture off
        directed_rows.push_back('{mk_item(CMD_INSERT, 0, 0, 0, 0, 0, 0), 1'b1,
                                  mk_want(ST_OK, 1, 0, 0)});
        directed_rows.push_back('{mk_item(CMD_INSERT, 0, 0, 1, '1, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_item(CMD_INSERT, 0, 1, 0, 16'h5a5a, 0, 1), 1'b0, '0});
        directed_rows.push_back('{mk_item(CMD_LOOKUP, 0, 0, 0, 0, 1, 0), 1'b0, '0});
        // off to on through a bad bucket: everything emptied
        directed_rows.push_back('{mk_item(CMD_CAPTURE, 255, 0, 0, 0, 0, 1), 1'b1,
                                  mk_want(ST_OK, 0, 1, 0)});
        directed_rows.push_back('{mk_item(CMD_LOOKUP, BUCKETS - 1, 0, 0, 0, 0, 0), 1'b1,
                                  mk_want(ST_BAD_IDX, 0, 1, 0)});
        directed_rows.push_back('{mk_item(CMD_NOP, 0, 0, 0, 0, 0, 0), 1'b1,
                                  mk_want(ST_OK, 0, 1, 0)});
        directed_rows.push_back('{mk_item(CMD_CAPTURE, BUCKETS, 0, 0, 0, 0, 0), 1'b1,
                                  mk_want(ST_OK, 0, 0, 0)});
        directed_rows.push_back('{mk_item(CMD_CAPTURE, 1, 0, 0, 0, 0, 1), 1'b1,
                                  mk_want(ST_OK, 0, 1, 0)});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[n])
            send_item(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].want);

        // random phases; the sender holds off until the store has drained
        // before each one
        for (int ph = 0; ph < 3; ph++) begin
            s_valid <= 1'b0;
            do @(posedge clk); while (expected_results.size() != 0);
            case (ph)
                0: begin
                    send_gap_pct   = 21;
                    recv_stall_pct = 72;
                end
                1: begin
                    send_gap_pct   = 72;
                    recv_stall_pct = 21;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            hot_bkt[0] = $urandom_range(0, BUCKETS - 1);
            hot_bkt[1] = $urandom_range(0, BUCKETS - 1);
            repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, '0);
        end

        s_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
